>>> src/thread_lockup_detector_defines.svh
// Assertion macros for the thread lockup detector.
// Used by the top level; no other dependencies.
`ifndef THREAD_LOCKUP_DETECTOR_DEFINES_SVH
`define THREAD_LOCKUP_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define TLD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define TLD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TLD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TLD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> src/tld_pkg.sv
// Shared widths, constants, register codes and structs of the thread lockup detector.
// No dependencies; every other file but the defines header uses it.
package tld_pkg;

    localparam int ID_W       = 16;
    localparam int STATE_W    = 8;
    localparam int COUNT_W    = 7;
    localparam int HELD_W     = 3;
    localparam int LIMIT_W    = 8;
    localparam int FLOOR_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_THREADS    = 64;
    localparam int WINDOW_SAMPLES = 6;
    localparam int TALLY_CAP      = (MAX_THREADS < 127) ? MAX_THREADS : 127;

    localparam logic [LIMIT_W-1:0] PAIR_LIMIT_RST = LIMIT_W'(36);
    localparam logic [FLOOR_W-1:0] FLOOR_RST      = FLOOR_W'(18);
    localparam logic [ID_W-1:0]    SKIP_FIRST_RST  = ID_W'(12);
    localparam logic [ID_W-1:0]    SKIP_SECOND_RST = ID_W'(1);

    localparam logic [STATE_W-1:0] STATE_RUNNING = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIR_LIMIT  = 2'd0,
        CFG_FLOOR       = 2'd1,
        CFG_SKIP_FIRST  = 2'd2,
        CFG_SKIP_SECOND = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] pair_sum_limit;
        logic [FLOOR_W-1:0] per_sample_floor;
    } t_win_cfg;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_win_push;

    typedef struct packed {
        logic              lock_detected;
        logic [HELD_W-1:0] samples_held;
    } t_win_res;

endpackage

>>> src/tld_rec_if.sv
// Input channel of the thread lockup detector: one thread record per transfer.
// Depends on tld_pkg for field widths.
interface tld_rec_if;
    logic                       valid;
    logic                       ready;
    logic [tld_pkg::ID_W-1:0]   thread_id;
    logic [tld_pkg::STATE_W-1:0] thread_state;
    logic                       end_of_sweep;

    modport source (output valid, thread_id, thread_state, end_of_sweep, input ready);
    modport sink   (input valid, thread_id, thread_state, end_of_sweep, output ready);
endinterface

>>> src/tld_res_if.sv
// Result channel of the thread lockup detector: one sweep verdict per transfer.
// Depends on tld_pkg for field widths.
interface tld_res_if;
    logic                        valid;
    logic                        ready;
    logic                        lock_detected;
    logic [tld_pkg::COUNT_W-1:0] sweep_running;
    logic [tld_pkg::HELD_W-1:0]  samples_held;

    modport source (output valid, lock_detected, sweep_running, samples_held, input ready);
    modport sink   (input valid, lock_detected, sweep_running, samples_held, output ready);
endinterface

>>> src/tld_window.sv
// Six-slot sample window with the two-, four- and six-sample checks.
// Depends on tld_pkg.
module tld_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tld_pkg::t_win_cfg  i_cfg,
    input  tld_pkg::t_win_push i_push,
    output tld_pkg::t_win_res  o_res
);
    import tld_pkg::*;

    localparam int SUM2_W = COUNT_W + 1;
    localparam int SUM_W  = COUNT_W + 3;

    logic [COUNT_W-1:0] r_win [WINDOW_SAMPLES];
    logic [HELD_W-1:0]  r_idx;
    logic [HELD_W-1:0]  idx_eff;
    logic [HELD_W-1:0]  n_idx;
    logic [COUNT_W-1:0] w [WINDOW_SAMPLES];
    logic [SUM2_W-1:0]  sum2;
    logic [SUM_W-1:0]   sum4;
    logic [SUM_W-1:0]   sum6;
    logic [SUM_W-1:0]   floor4;
    logic [SUM_W-1:0]   floor6;
    logic               eq4;
    logic               eq6;

    // An index past the last slot never occurs, but would restart at slot zero.
    assign idx_eff = (r_idx > HELD_W'(WINDOW_SAMPLES - 1)) ? '0 : r_idx;

    // Window as it stands once the new sample is in place.
    always_comb begin
        for (int k = 0; k < WINDOW_SAMPLES; k++) begin
            w[k] = (idx_eff == HELD_W'(k)) ? i_push.count : r_win[k];
        end
    end

    assign sum2   = SUM2_W'(w[0]) + SUM2_W'(w[1]);
    assign sum4   = SUM_W'(sum2) + SUM_W'(w[2]) + SUM_W'(w[3]);
    assign sum6   = sum4 + SUM_W'(w[4]) + SUM_W'(w[5]);
    assign floor4 = SUM_W'({i_cfg.per_sample_floor, 2'b00});
    assign floor6 = floor4 + SUM_W'({i_cfg.per_sample_floor, 1'b0});
    assign eq4    = (w[1] == w[0]) && (w[2] == w[0]) && (w[3] == w[0]);
    assign eq6    = eq4 && (w[4] == w[0]) && (w[5] == w[0]);

    always_comb begin
        o_res.lock_detected = 1'b0;
        n_idx               = idx_eff + 1'b1;
        case (n_idx)
            HELD_W'(2): begin
                if (!((sum2 > SUM2_W'(i_cfg.pair_sum_limit)) && (w[1] >= w[0]))) begin
                    n_idx = '0;
                end
            end
            HELD_W'(4): begin
                if (!((sum4 >= floor4) && eq4)) begin
                    n_idx = '0;
                end
            end
            HELD_W'(WINDOW_SAMPLES): begin
                o_res.lock_detected = (sum6 >= floor6) && eq6;
                n_idx               = '0;
            end
            default: ;
        endcase
        o_res.samples_held = n_idx;
    end

    // Slots left stale by a restart are rewritten before they are read again.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_win[idx_eff] <= i_push.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_push.valid) begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> src/thread_lockup_detector.sv
// Top level of the thread lockup detector: input register, running tally,
// configuration registers and result register. Depends on tld_pkg, tld_rec_if,
// tld_res_if, tld_window and thread_lockup_detector_defines.svh.
//
// Usage: the source streams thread records over i_rec, one per transfer; the
// last record of a scheduler sweep carries end_of_sweep. Records whose state is
// zero and whose id matches neither skip id are counted (saturating at the
// thread limit). The closing record of a sweep yields exactly one transfer on
// o_res with the sweep count, the samples now held in the six-slot window and
// the lock flag; other records yield nothing.
// Throughput is one record per cycle unless a closing record waits on a full result
// register; the tally and window check between the input and result registers are
// combinational. An accepted closing record reaches o_res through both registers.
// Reset (synchronous, active low) empties both registers, clears the tally and
// the window index and loads the configuration defaults: pair limit 36,
// per-sample floor 18, skip ids 12 and 1.
// When the receiver stalls, the result stays in the output register while
// records that do not close a sweep keep flowing; a second closing record
// waits in the input register, and only then does i_rec.ready drop.
// Configuration writes take effect at the next edge; write only while idle (the block does not enforce it).
module thread_lockup_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tld_rec_if.sink                        i_rec,
    tld_res_if.source                      o_res
);
    import tld_pkg::*;

    `include "thread_lockup_detector_defines.svh"

    // Configuration registers.
    logic [LIMIT_W-1:0] r_pair_limit;
    logic [FLOOR_W-1:0] r_floor;
    logic [ID_W-1:0]    r_skip_first;
    logic [ID_W-1:0]    r_skip_second;

    // Input register.
    logic               r_in_valid;
    logic [ID_W-1:0]    r_in_id;
    logic [STATE_W-1:0] r_in_state;
    logic               r_in_last;

    // Running tally of the current sweep.
    logic [COUNT_W-1:0] r_tally;
    logic [COUNT_W-1:0] n_tally;
    logic               count_it;

    // Result register.
    logic               r_out_valid;
    logic               r_out_lock;
    logic [COUNT_W-1:0] r_out_count;
    logic [HELD_W-1:0]  r_out_held;

    logic      out_free;
    logic      proc;
    t_win_cfg  win_cfg;
    t_win_push win_push;
    t_win_res  win_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_limit  <= PAIR_LIMIT_RST;
            r_floor       <= FLOOR_RST;
            r_skip_first  <= SKIP_FIRST_RST;
            r_skip_second <= SKIP_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAIR_LIMIT:  r_pair_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_FLOOR:       r_floor       <= i_cfg_data[FLOOR_W-1:0];
                CFG_SKIP_FIRST:  r_skip_first  <= i_cfg_data[ID_W-1:0];
                CFG_SKIP_SECOND: r_skip_second <= i_cfg_data[ID_W-1:0];
            endcase
        end
    end

    // The held record moves on unless it closes a sweep while the result
    // register is still full and not being taken.
    assign out_free    = !r_out_valid || o_res.ready;
    assign proc        = r_in_valid && (!r_in_last || out_free);
    assign i_rec.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rec.ready) begin
            r_in_valid <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec.valid && i_rec.ready) begin
            r_in_id    <= i_rec.thread_id;
            r_in_state <= i_rec.thread_state;
            r_in_last  <= i_rec.end_of_sweep;
        end
    end

    // The closing record is counted before the sweep total is taken.
    assign count_it = (r_in_state == STATE_RUNNING) && (r_in_id != r_skip_first)
                   && (r_in_id != r_skip_second) && (r_tally < COUNT_W'(TALLY_CAP));
    assign n_tally  = r_tally + COUNT_W'(count_it);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (proc) begin
            r_tally <= r_in_last ? '0 : n_tally;
        end
    end

    assign win_cfg.pair_sum_limit   = r_pair_limit;
    assign win_cfg.per_sample_floor = r_floor;
    assign win_push.valid           = proc && r_in_last;
    assign win_push.count           = n_tally;

    tld_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (win_cfg),
        .i_push  (win_push),
        .o_res   (win_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (win_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_push.valid) begin
            r_out_lock  <= win_res.lock_detected;
            r_out_count <= n_tally;
            r_out_held  <= win_res.samples_held;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.lock_detected = r_out_lock;
    assign o_res.sweep_running = r_out_count;
    assign o_res.samples_held  = r_out_held;

    // A lock verdict always restarts the window.
    `TLD_ASSERT_IMP(a_lock_empties_window, i_clk, i_rst_n,
        o_res.valid && o_res.lock_detected, o_res.samples_held == '0)

    // Closing a sweep clears the tally for the next one.
    `TLD_ASSERT_NXT(a_tally_clears, i_clk, i_rst_n, proc && r_in_last, r_tally == '0)

    // A closing record that cannot move stays in the input register.
    `TLD_ASSERT_NXT(a_stalled_record_held, i_clk, i_rst_n, r_in_valid && !proc,
        r_in_valid && r_in_last && $stable(r_in_id) && $stable(r_in_state))

endmodule
